### rtl/hfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types, constants and helper functions of the hex fragment
// reassembler: parse phases, tag match codes, result records and hex decode.
// ----------------------------------------------------------------------------
package hfr_pkg;

    // Assembly buffer size in bytes
    localparam int BUFFER_BYTES = 1024;
    // Nibble counter: counts up to and including 2 * BUFFER_BYTES
    localparam int NIB_W        = $clog2(2 * BUFFER_BYTES + 1);
    localparam logic [NIB_W-1:0] NIB_CAP = NIB_W'(2 * BUFFER_BYTES);

    // Result field widths
    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 10;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 11;
    localparam int NUM_W    = 16;
    localparam int TDATA_W  = 32;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_AT   = 8'h40;
    localparam logic [CHAR_W-1:0] CH_F    = 8'h46;
    localparam logic [NUM_W-1:0]  NUM_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_ID    = 3'd1,
        PH_COUNT = 3'd2,
        PH_DATA  = 3'd3,
        PH_AFTER = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_AT   = 2'd1,
        TAG_OK   = 2'd2,
        TAG_BAD  = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_MORE   = 2'd1,
        ST_DONE   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef struct packed {
        phase_t            phase;
        logic              in_token;
        tag_t              tag;
        logic [NUM_W-1:0]  id_acc;
        logic [NUM_W-1:0]  cnt_acc;
        logic              num_done;
        logic              accepted;
        logic [7:0]        last_id;
        logic [7:0]        frag_count;
        logic [NIB_W-1:0]  nib;
        logic [BYTE_W-1:0] hold;
    } hfr_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   value;
        status_t             status;
        logic [LEN_W-1:0]    length;
        logic                last;
    } hfr_result_t;

    // Results produced by one character, in order: first, then second
    typedef struct packed {
        logic [1:0]  count;
        hfr_result_t first;
        hfr_result_t second;
    } hfr_push_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_nib_t;

    function automatic hex_nib_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_nib_t r;
        r.valid = 1'b0;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.valid = 1'b1;
            r.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.valid = 1'b1;
            r.value = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    // Acceptance already settled for this message
    function automatic logic is_decided(input phase_t ph, input logic in_tok);
        return (ph == PH_AFTER) || (ph == PH_STOP) || (ph == PH_DATA && in_tok);
    endfunction

endpackage
`default_nettype wire

### rtl/hex_fragment_reassembler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_fragment_reassembler
// Parses "@F;id;count;hexdata" messages one character per transaction and
// emits the decoded bytes of accepted fragments plus one report per message.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata                                   tuser         tlast
//  -------  ---  --------------------------------------  ------------  ----------------
//  s_       in   [7:0] char_in                           -             end_of_message
//  m_       out  [9:0] byte_offset, [17:10] byte_value,  result_kind   last_result
//                [19:18] fragment_status,
//                [30:20] assembled_length, [31] zero
//
//  One character is taken per cycle; it updates the parse state in the same
//  cycle and places zero, one or two results into a four-entry output queue.
//  s_tready drops only while the queue holds more than two results, so the
//  sustained input rate is one character per cycle as long as m_tready keeps
//  up with about one result per character (the queue's single read port).
//  Reset (aresetn low, synchronous) clears the parse state, the fragment
//  bookkeeping and the queue; no clearing pass is needed.
//  A stalled m_ side holds its head result stable until taken.
//
module hex_fragment_reassembler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hfr_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_in
    input  wire logic                          s_tlast,   // end_of_message
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hfr_pkg::TDATA_W-1:0]        m_tdata,   // offset, value, status, length
    output logic                               m_tuser,   // result_kind
    output logic                               m_tlast    // last_result
);
    import hfr_pkg::*;

    hfr_state_t  state_reg;
    hfr_state_t  state_next;
    hfr_push_t   push;
    hfr_result_t head;
    logic        s_fire;

    assign s_fire = s_tvalid && s_tready;

    // Per-character logic: tokenizer, decision and hex pairing
    hfr_step u_step (
        .char_in    (s_tdata),
        .eom        (s_tlast),
        .state_cur  (state_reg),
        .state_next (state_next),
        .push       (push)
    );

    // Advance state only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Queue results; it also decouples input acceptance from output stalls
    hfr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (s_fire),
        .push      (push),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // Pack the head result onto the stream
    assign m_tdata = {1'b0, head.length, head.status, head.value, head.offset};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // The nibble counter never runs past the buffer
    a_nib_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.nib <= NIB_CAP)
        else $error("nibble index past buffer capacity");

    // After a NUL the tokenizer is never inside a token
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_STOP |-> !state_reg.in_token)
        else $error("in_token set after NUL");

    // Message end returns the parse state to the tag field
    a_eom_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> state_reg.phase == PH_TAG && !state_reg.in_token &&
                              state_reg.tag == TAG_NONE && !state_reg.accepted)
        else $error("parse state not cleared at message end");

    // Every end-of-message transaction queues exactly one report as the last result
    a_eom_report: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |-> push.count != 2'd0 &&
            ((push.count == 2'd1 && push.first.kind == KIND_REPORT) ||
             (push.count == 2'd2 && push.second.kind == KIND_REPORT)))
        else $error("missing end-of-message report");

endmodule
`default_nettype wire

### rtl/hfr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_step
// Next-state and result logic for one character: tokenizer, tag check,
// decimal fields, acceptance decision, hex pairing and end-of-message report.
// ----------------------------------------------------------------------------
module hfr_step (
    input  wire logic [hfr_pkg::CHAR_W-1:0] char_in,
    input  wire logic                       eom,
    input  wire hfr_pkg::hfr_state_t        state_cur,
    output hfr_pkg::hfr_state_t             state_next,
    output hfr_pkg::hfr_push_t              push
);
    import hfr_pkg::*;

    function automatic logic [NUM_W-1:0] add_dec(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] d);
        logic [NUM_W+3:0] ext;
        logic [NUM_W+3:0] v;
        ext = {4'b0, acc};
        v   = (ext << 3) + (ext << 1) + {{NUM_W{1'b0}}, d};
        return (v > {4'b0, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
    endfunction

    hfr_state_t  st;
    hfr_result_t data_res;
    hfr_result_t rep_res;
    hex_nib_t    hv;
    logic        is_delim;
    logic        is_digit;
    logic        decide_fire;
    logic        hex_go;
    logic        ok;

    always_comb begin
        st          = state_cur;
        decide_fire = 1'b0;
        hex_go      = 1'b0;
        ok          = 1'b0;
        hv          = hex_decode(char_in);
        is_delim    = (char_in == CH_SEMI) || (char_in == CH_CR) || (char_in == CH_LF);
        is_digit    = (char_in >= 8'h30) && (char_in <= 8'h39);
        data_res    = '0;
        rep_res     = '0;
        push        = '0;

        if (state_cur.phase == PH_STOP) begin
            // text ended by NUL: ignore until the end mark
        end else if (char_in == CH_NUL) begin
            decide_fire = !is_decided(state_cur.phase, state_cur.in_token);
            st.phase    = PH_STOP;
            st.in_token = 1'b0;
        end else if (is_delim) begin
            if (state_cur.in_token) begin
                st.in_token = 1'b0;
                unique case (state_cur.phase)
                    PH_TAG:   st.phase = PH_ID;
                    PH_ID:    st.phase = PH_COUNT;
                    PH_COUNT: st.phase = PH_DATA;
                    PH_DATA:  st.phase = PH_AFTER;
                    default:  st.phase = state_cur.phase;
                endcase
            end
        end else begin
            if (!state_cur.in_token) begin
                st.in_token = 1'b1;
                st.num_done = 1'b0;
                if (state_cur.phase == PH_DATA) begin
                    decide_fire = 1'b1;
                end
            end
            unique case (state_cur.phase)
                PH_TAG: begin
                    if (state_cur.tag == TAG_NONE && char_in == CH_AT) begin
                        st.tag = TAG_AT;
                    end else if (state_cur.tag == TAG_AT && char_in == CH_F) begin
                        st.tag = TAG_OK;
                    end else begin
                        st.tag = TAG_BAD;
                    end
                end
                PH_ID: begin
                    if (!st.num_done) begin
                        if (is_digit) st.id_acc = add_dec(st.id_acc, char_in[3:0]);
                        else          st.num_done = 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (!st.num_done) begin
                        if (is_digit) st.cnt_acc = add_dec(st.cnt_acc, char_in[3:0]);
                        else          st.num_done = 1'b1;
                    end
                end
                PH_DATA: hex_go = 1'b1;
                default: ;
            endcase
        end

        if (eom && !is_decided(st.phase, st.in_token)) begin
            decide_fire = 1'b1;
        end

        // Accept or reject the fragment; at most one decision per character
        if (decide_fire) begin
            if (st.tag == TAG_OK) begin
                if (st.id_acc == '0) begin
                    st.frag_count = st.cnt_acc[7:0];
                    st.last_id    = 8'd0;
                    st.nib        = '0;
                    ok            = 1'b1;
                end else if (({8'b0, state_cur.last_id} + 16'd1 == st.id_acc) &&
                             ({8'b0, state_cur.frag_count} == st.cnt_acc)) begin
                    st.last_id = st.id_acc[7:0];
                    ok         = 1'b1;
                end
            end
            st.accepted = ok;
        end

        if (hex_go && st.accepted && st.nib < NIB_CAP) begin
            if (!st.nib[0]) begin
                if (hv.valid) st.hold = {4'b0, hv.value};
            end else begin
                st.hold         = {st.hold[3:0], (hv.valid ? hv.value : 4'd0)};
                data_res.kind   = KIND_DATA;
                data_res.offset = OFFSET_W'(st.nib >> 1);
                data_res.value  = st.hold;
                data_res.status = ST_REJECT;
                data_res.last   = !eom;
                push.count      = 2'd1;
                push.first      = data_res;
            end
            st.nib = st.nib + NIB_W'(1);
        end

        if (eom) begin
            rep_res.kind   = KIND_REPORT;
            rep_res.status = ST_REJECT;
            rep_res.last   = 1'b1;
            if (st.accepted) begin
                if ({1'b0, st.last_id} + 9'd1 == {1'b0, st.frag_count}) begin
                    rep_res.status = ST_DONE;
                    rep_res.length = LEN_W'(st.nib >> 1);
                end else begin
                    rep_res.status = ST_MORE;
                end
            end
            if (push.count == 2'd0) push.first  = rep_res;
            else                    push.second = rep_res;
            push.count = push.count + 2'd1;
            // drop per-message parse state
            st.phase    = PH_TAG;
            st.in_token = 1'b0;
            st.tag      = TAG_NONE;
            st.id_acc   = '0;
            st.cnt_acc  = '0;
            st.num_done = 1'b0;
            st.accepted = 1'b0;
        end

        state_next = st;
    end

endmodule
`default_nettype wire

### rtl/hfr_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_out_fifo
// Small result queue: takes up to two results per cycle, gives one per
// transaction, and keeps the input side running while the output stalls until it holds more than two results.
// ----------------------------------------------------------------------------
module hfr_out_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_en,
    input  wire hfr_pkg::hfr_push_t    push,
    output logic                       has_room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hfr_pkg::hfr_result_t       out_res
);
    import hfr_pkg::*;

    hfr_result_t       mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        n_push;
    logic              pop;

    assign n_push    = push_en ? push.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign has_room  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_res   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire
